// ===== hw/rtl/nvcm_pkg.sv =====
// nvcm_pkg: shared types, constants and binary64 helper functions
// for the newton convergence monitor; no dependencies
package nvcm_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [63:0] LARGEST_DOUBLE = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FP_QNAN        = 64'h7FF8_0000_0000_0000;

  // multiplier latency in cycles, inputs to registered product
  localparam int FMUL_LAT  = 5;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;

  // status codes
  localparam logic [1:0] ST_ITERATING = 2'd0;
  localparam logic [1:0] ST_CONVERGED = 2'd1;
  localparam logic [1:0] ST_DIVERGED  = 2'd2;

  // reason codes
  localparam logic [3:0] RS_NONE     = 4'd0;
  localparam logic [3:0] RS_DOMAIN   = 4'd1;
  localparam logic [3:0] RS_NAN      = 4'd2;
  localparam logic [3:0] RS_ABS      = 4'd3;
  localparam logic [3:0] RS_EVALS    = 4'd4;
  localparam logic [3:0] RS_BLOWUP   = 4'd5;
  localparam logic [3:0] RS_REL      = 4'd6;
  localparam logic [3:0] RS_STEP     = 4'd7;
  localparam logic [3:0] RS_RELDIV   = 4'd8;
  localparam logic [3:0] RS_ABSDIV   = 4'd9;
  localparam logic [3:0] RS_PINGPONG = 4'd10;

  // register indexes
  localparam logic [2:0] REG_ABS_TOL      = 3'd0;
  localparam logic [2:0] REG_REL_TOL      = 3'd1;
  localparam logic [2:0] REG_STEP_TOL     = 3'd2;
  localparam logic [2:0] REG_MAX_EVALS    = 3'd3;
  localparam logic [2:0] REG_FORCED_ITERS = 3'd4;
  localparam logic [2:0] REG_REL_DIV_TOL  = 3'd5;
  localparam logic [2:0] REG_ABS_DIV_TOL  = 3'd6;
  localparam logic [2:0] REG_MAX_PINGPONG = 3'd7;

  typedef struct packed {
    logic [15:0] iteration;
    logic [63:0] residual_norm;
    logic [63:0] solution_norm;
    logic [63:0] update_norm;
    logic [63:0] reference_norm;
    logic [15:0] evaluation_count;
    logic        domain_error;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] reason;
  } result_t;

  typedef struct packed {
    logic [63:0] abs_tolerance;
    logic [63:0] rel_tolerance;
    logic [63:0] rel_step_tolerance;
    logic [15:0] max_evaluations;
    logic [15:0] forced_iterations;
    logic [63:0] rel_div_tolerance;
    logic [63:0] abs_div_tolerance;
    logic [15:0] max_pingpong;
  } cfg_t;

  // classified transaction passed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  reason;
    logic        run_second;
    logic        pingpong_over;
    logic [63:0] residual;
    logic [63:0] solution;
    logic [63:0] update;
    logic [63:0] reference;
  } mid_t;

  function automatic logic fp_isnan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic [63:0] fp_key(input logic [63:0] x);
    return x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic both_zero;
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    return !fp_isnan(a) && !fp_isnan(b) && !both_zero && (fp_key(a) < fp_key(b));
  endfunction

  function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
    logic both_zero;
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    return !fp_isnan(a) && !fp_isnan(b) && (both_zero || (fp_key(a) <= fp_key(b)));
  endfunction

  function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
    return fp_lt(b, a);
  endfunction

  function automatic logic fp_ge(input logic [63:0] a, input logic [63:0] b);
    return fp_le(b, a);
  endfunction

  // leading zero count of a 106-bit product
  function automatic logic [6:0] lzc106(input logic [105:0] m);
    logic [6:0] n;
    n = 7'd106;
    for (int i = 0; i < 106; i++) begin
      if (m[i]) n = 7'(105 - i);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/nvcm_queue.sv =====
// nvcm_queue: two-entry queue of classified transactions between front and back
// depends on nvcm_pkg
module nvcm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  nvcm_pkg::mid_t wdata,
  output logic          full,
  input  logic          rd_en,
  output nvcm_pkg::mid_t rdata,
  output logic          valid
);
  import nvcm_pkg::*;

  mid_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/nvcm_front.sv =====
// nvcm_front: accepts reports, updates residual history and ping-pong count,
// runs the first check chain; depends on nvcm_pkg
module nvcm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  nvcm_pkg::item_t item,
  input  nvcm_pkg::cfg_t  cfg,
  output nvcm_pkg::mid_t  rec
);
  import nvcm_pkg::*;

  logic [63:0]           last_residual;
  logic [COUNT_BITS-1:0] pingpong_count;
  logic [COUNT_BITS-1:0] pingpong_count_next;
  logic [COUNT_BITS-1:0] pc_base;
  logic [63:0]           old_res;
  logic                  iter_zero;
  logic                  rise;
  logic                  active;
  logic [1:0]            st;
  logic [3:0]            rs;

  always_comb begin
    iter_zero = (item.iteration == 16'd0);
    old_res   = iter_zero ? item.residual_norm : last_residual;
    pc_base   = iter_zero ? '0 : pingpong_count;
    rise      = fp_gt(item.residual_norm, old_res);
    if (pc_base[0] != rise) begin
      pingpong_count_next = (pc_base == COUNT_MAX) ? pc_base : pc_base + 1'b1;
    end else begin
      pingpong_count_next = '0;
    end

    active = (item.iteration >= cfg.forced_iterations);
    st = ST_ITERATING;
    rs = RS_NONE;
    if (fp_isnan(item.residual_norm)) begin
      st = ST_DIVERGED;  rs = RS_NAN;
    end else if (active && fp_lt(item.residual_norm, cfg.abs_tolerance)) begin
      st = ST_CONVERGED; rs = RS_ABS;
    end else if (item.evaluation_count >= cfg.max_evaluations) begin
      st = ST_DIVERGED;  rs = RS_EVALS;
    end else if (active && !iter_zero && fp_gt(item.residual_norm, last_residual)
                 && fp_ge(item.residual_norm, LARGEST_DOUBLE)) begin
      st = ST_DIVERGED;  rs = RS_BLOWUP;
    end else if (item.domain_error) begin
      st = ST_DIVERGED;  rs = RS_DOMAIN;
    end

    rec.status        = st;
    rec.reason        = rs;
    rec.run_second    = active && !iter_zero && (st == ST_ITERATING);
    rec.pingpong_over = CMP_W'(pingpong_count_next) > CMP_W'(cfg.max_pingpong);
    rec.residual      = item.residual_norm;
    rec.solution      = item.solution_norm;
    rec.update        = item.update_norm;
    rec.reference     = item.reference_norm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_residual  <= 64'd0;
      pingpong_count <= '0;
    end else if (accept) begin
      last_residual  <= item.residual_norm;
      pingpong_count <= pingpong_count_next;
    end
  end

endmodule

// ===== hw/rtl/nvcm_fmul.sv =====
// nvcm_fmul: five-stage binary64 multiplier, round to nearest even
// depends on nvcm_pkg
module nvcm_fmul (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  import nvcm_pkg::*;

  typedef struct packed {
    logic sign;
    logic is_nan;
    logic is_inf;
    logic is_zero;
  } spec_t;

  // stage 1 comb
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [52:0] ma, mb;
  spec_t       sp0;

  // registers
  spec_t              sp1, sp2, sp3, sp4;
  logic [53:0]        pp_hh;
  logic [52:0]        pp_hl, pp_lh;
  logic [51:0]        pp_ll;
  logic [11:0]        esum1, esum2;
  logic [105:0]       prod2, prod3;
  logic [6:0]         lz3;
  logic signed [12:0] e3, e4;
  logic [105:0]       m4;

  // stage 5 comb
  logic [169:0] ext;
  logic [5:0]   shc;
  logic [11:0]  base;
  logic [52:0]  k;
  logic         g, stk, inc;
  logic [63:0]  sum;
  logic [63:0]  p_next;
  logic signed [12:0] sh_full;

  always_comb begin
    a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    a_zero = (a[62:0] == 63'd0);
    b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    b_zero = (b[62:0] == 63'd0);
    ma = {a[62:52] != 11'd0, a[51:0]};
    mb = {b[62:52] != 11'd0, b[51:0]};
    sp0.sign    = a[63] ^ b[63];
    sp0.is_nan  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
    sp0.is_inf  = (a_inf || b_inf) && !sp0.is_nan;
    sp0.is_zero = (a_zero || b_zero) && !sp0.is_nan;
  end

  always_ff @(posedge clk) begin
    // partial products, each no wider than 27 x 27
    pp_hh <= ma[52:26] * mb[52:26];
    pp_hl <= 53'(ma[52:26]) * 53'(mb[25:0]);
    pp_lh <= 53'(ma[25:0]) * 53'(mb[52:26]);
    pp_ll <= ma[25:0] * mb[25:0];
    esum1 <= ((a[62:52] == 11'd0) ? 12'd1 : {1'b0, a[62:52]})
           + ((b[62:52] == 11'd0) ? 12'd1 : {1'b0, b[62:52]});
    sp1   <= sp0;
    // full product
    prod2 <= {pp_hh, 52'd0} + {27'd0, pp_hl, 26'd0} + {27'd0, pp_lh, 26'd0}
           + {54'd0, pp_ll};
    esum2 <= esum1;
    sp2   <= sp1;
    // leading zeros and biased exponent
    prod3 <= prod2;
    lz3   <= lzc106(prod2);
    e3    <= $signed({1'b0, esum2}) - 13'sd1022 - $signed({6'd0, lzc106(prod2)});
    sp3   <= sp2;
    // normalize
    m4    <= prod3 << lz3;
    e4    <= e3;
    sp4   <= sp3;
    // denormalize, round, pack
    p     <= p_next;
  end

  always_comb begin
    sh_full = 13'sd1 - e4;
    if (e4 >= 13'sd1) begin
      shc  = 6'd0;
      base = 12'(e4 - 13'sd1);
    end else begin
      shc  = (sh_full > 13'sd63) ? 6'd63 : sh_full[5:0];
      base = 12'd0;
    end
    ext = {m4, 64'd0} >> shc;
    k   = ext[169:117];
    g   = ext[116];
    stk = |ext[115:0];
    inc = g && (stk || k[0]);
    sum = {base, 52'd0} + {11'd0, k} + {63'd0, inc};
    if (sp4.is_nan) begin
      p_next = FP_QNAN;
    end else if (sp4.is_inf || (sum[63:52] >= 12'h7FF)) begin
      p_next = {sp4.sign, 11'h7FF, 52'd0};
    end else if (sp4.is_zero) begin
      p_next = {sp4.sign, 63'd0};
    end else begin
      p_next = {sp4.sign, sum[62:0]};
    end
  end

endmodule

// ===== hw/rtl/nvcm_back.sv =====
// nvcm_back: products for relative tests, second check chain and result queue
// depends on nvcm_pkg, nvcm_fmul
module nvcm_back (
  input  logic            clk,
  input  logic            rst,
  input  nvcm_pkg::cfg_t   cfg,
  input  logic            rec_valid,
  input  nvcm_pkg::mid_t   rec,
  output logic            rec_take,
  output logic            empty,
  input  logic            pop,
  output nvcm_pkg::result_t result
);
  import nvcm_pkg::*;

  logic [63:0] p_rel, p_step, p_rdiv;
  mid_t        dl   [FMUL_LAT];
  logic        dl_v [FMUL_LAT];
  logic [OUT_AW:0]  reserved;
  logic [OUT_AW:0]  count;
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  result_t     outq [OUT_DEPTH];
  result_t     res;
  logic        out_pop;
  mid_t        cur;

  nvcm_fmul u_mul_rel  (.clk(clk), .a(rec.reference), .b(cfg.rel_tolerance), .p(p_rel));
  nvcm_fmul u_mul_step (.clk(clk), .a(cfg.rel_step_tolerance), .b(rec.solution),
                        .p(p_step));
  nvcm_fmul u_mul_rdiv (.clk(clk), .a(rec.reference), .b(cfg.rel_div_tolerance),
                        .p(p_rdiv));

  assign rec_take = rec_valid && (reserved < (OUT_AW+1)'(OUT_DEPTH));
  assign out_pop  = pop && !empty;
  assign empty    = (count == '0);
  assign result   = outq[rd_ptr];
  assign cur      = dl[FMUL_LAT-1];

  always_comb begin
    res.status = cur.status;
    res.reason = cur.reason;
    if (cur.run_second) begin
      if (fp_le(cur.residual, p_rel)) begin
        res.status = ST_CONVERGED; res.reason = RS_REL;
      end else if (fp_lt(cur.update, p_step)) begin
        res.status = ST_CONVERGED; res.reason = RS_STEP;
      end else if (fp_gt(cfg.rel_div_tolerance, 64'd0) && fp_gt(cur.residual, p_rdiv)) begin
        res.status = ST_DIVERGED;  res.reason = RS_RELDIV;
      end else if (fp_gt(cfg.abs_div_tolerance, 64'd0)
                   && fp_gt(cur.residual, cfg.abs_div_tolerance)) begin
        res.status = ST_DIVERGED;  res.reason = RS_ABSDIV;
      end else if (cur.pingpong_over) begin
        res.status = ST_DIVERGED;  res.reason = RS_PINGPONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    dl[0] <= rec;
    for (int i = 1; i < FMUL_LAT; i++) dl[i] <= dl[i-1];
    if (dl_v[FMUL_LAT-1]) outq[wr_ptr] <= res;
    if (rst) begin
      for (int i = 0; i < FMUL_LAT; i++) dl_v[i] <= 1'b0;
      reserved <= '0;
      count    <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
    end else begin
      dl_v[0] <= rec_take;
      for (int i = 1; i < FMUL_LAT; i++) dl_v[i] <= dl_v[i-1];
      reserved <= reserved + (OUT_AW+1)'(rec_take) - (OUT_AW+1)'(out_pop);
      count    <= count + (OUT_AW+1)'(dl_v[FMUL_LAT-1]) - (OUT_AW+1)'(out_pop);
      if (dl_v[FMUL_LAT-1]) wr_ptr <= wr_ptr + 1'b1;
      if (out_pop) rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/newton_convergence_monitor_top.sv =====
// newton_convergence_monitor_top: register file and wiring of front, queue and back
// depends on nvcm_pkg, nvcm_front, nvcm_queue, nvcm_back
//
// judges one newton iteration report per transaction and returns iterating,
// converged or diverged with a reason code. the front takes one report every
// cycle while its two-entry queue has room; it keeps the previous residual and
// the ping-pong count and runs the nan, absolute, evaluation, blow-up and
// domain checks. the back pulls one report a cycle while the output queue has
// room, forms reference*rel_tol, step_tol*solution and reference*rel_div_tol in
// three five-stage binary64 multipliers, applies the relative checks and parks
// the result in an eight-entry output queue. a report's result passes through
// the queue, the delay line and the output queue to the result port, and one
// report per cycle is sustained as long as results are popped. configuration
// writes take effect at once and are to be done while no report is in flight.
module newton_convergence_monitor_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  nvcm_pkg::item_t    item,
  output logic              empty,
  input  logic              pop,
  output nvcm_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import nvcm_pkg::*;

  cfg_t cfg;
  mid_t front_rec;
  mid_t queue_rec;
  logic accept;
  logic queue_valid;
  logic queue_take;

  // input transaction accepted while the queue has room
  assign accept = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abs_tolerance      <= 64'd0;
      cfg.rel_tolerance      <= 64'd0;
      cfg.rel_step_tolerance <= 64'd0;
      cfg.max_evaluations    <= 16'hFFFF;
      cfg.forced_iterations  <= 16'd0;
      cfg.rel_div_tolerance  <= 64'd0;
      cfg.abs_div_tolerance  <= 64'd0;
      cfg.max_pingpong       <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ABS_TOL:      cfg.abs_tolerance      <= cfg_data;
        REG_REL_TOL:      cfg.rel_tolerance      <= cfg_data;
        REG_STEP_TOL:     cfg.rel_step_tolerance <= cfg_data;
        REG_MAX_EVALS:    cfg.max_evaluations    <= cfg_data[15:0];
        REG_FORCED_ITERS: cfg.forced_iterations  <= cfg_data[15:0];
        REG_REL_DIV_TOL:  cfg.rel_div_tolerance  <= cfg_data;
        REG_ABS_DIV_TOL:  cfg.abs_div_tolerance  <= cfg_data;
        REG_MAX_PINGPONG: cfg.max_pingpong       <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  // front: history state and first check chain
  nvcm_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .item(item), .cfg(cfg), .rec(front_rec)
  );

  // decoupling queue
  nvcm_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(accept), .wdata(front_rec), .full(full),
    .rd_en(queue_take), .rdata(queue_rec), .valid(queue_valid)
  );

  // back: products, second chain, result queue
  nvcm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .rec_valid(queue_valid), .rec(queue_rec),
    .rec_take(queue_take), .empty(empty), .pop(pop), .result(result)
  );

endmodule

// ===== hw/rtl/nvcm_checker.sv =====
// nvcm_checker: port-level assertions for the convergence monitor and its bind
// depends on nvcm_pkg, newton_convergence_monitor_top
module nvcm_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input nvcm_pkg::result_t  result
);
  import nvcm_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_iter_no_reason: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_ITERATING) |-> result.reason == RS_NONE)
    else $error("iterating result carries a reason");

  a_conv_reason: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_CONVERGED) |->
      (result.reason == RS_ABS || result.reason == RS_REL || result.reason == RS_STEP))
    else $error("converged result with a divergence reason");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status == ST_ITERATING || result.status == ST_CONVERGED
                || result.status == ST_DIVERGED))
    else $error("undefined status code");

endmodule

bind newton_convergence_monitor_top nvcm_checker u_nvcm_checker (
  .clk(clk), .rst(rst), .empty(empty), .result(result)
);

// ===== bench/tb_newton_convergence_monitor_top.sv =====
// tb_newton_convergence_monitor_top: self-checking bench for the newton convergence monitor
// depends on nvcm_pkg and newton_convergence_monitor_top; needs no files or arguments
`timescale 1ns / 100ps

module tb_newton_convergence_monitor_top;
  import nvcm_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // dut ports, inputs driven to known values from time zero
  logic        push = 1'b0;
  logic        full;
  item_t       item = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_ABS_TOL;
  logic [63:0] cfg_data = '0;

  newton_convergence_monitor_top u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_TWO  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] DBL_HALF = 64'h3FE0_0000_0000_0000;
  localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NEG0 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DBL_MONE = 64'hBFF0_0000_0000_0000;
  localparam logic [15:0] CNT_TOP  = 16'hFFFF;
  localparam int          IDLE_LIMIT = 3000;

  // mirror of the register file and the judged state
  cfg_t        cfg_mirror;
  logic [63:0] prev_residual;
  logic [15:0] swing_count;

  // verdicts waiting for the result port
  result_t verdict_q[$];

  int items_sent = 0;
  int verdicts_seen = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int burst_left = 8;
  int idle_cycles = 0;
  bit hold_done = 1'b0;
  int verdict_hist[16];

  // ---------------------------------------------------------------------------
  // binary64 helpers: ordering on bit patterns, nan compares false
  // ---------------------------------------------------------------------------
  function automatic bit is_nan64(logic [63:0] a);
    return (a[62:52] == 11'h7FF) && (a[51:0] != 0);
  endfunction

  function automatic logic [63:0] order_key(logic [63:0] a);
    return a[63] ? ~a : (a | 64'h8000_0000_0000_0000);
  endfunction

  function automatic bit dbl_lt(logic [63:0] a, logic [63:0] b);
    if (is_nan64(a) || is_nan64(b)) return 1'b0;
    if (a[62:0] == 0 && b[62:0] == 0) return 1'b0;
    return order_key(a) < order_key(b);
  endfunction

  function automatic bit dbl_le(logic [63:0] a, logic [63:0] b);
    if (is_nan64(a) || is_nan64(b)) return 1'b0;
    if (a[62:0] == 0 && b[62:0] == 0) return 1'b1;
    return order_key(a) <= order_key(b);
  endfunction

  // product rounded as the simulator's own double multiply does
  function automatic logic [63:0] dbl_mul(logic [63:0] a, logic [63:0] b);
    return $realtobits($bitstoreal(a) * $bitstoreal(b));
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: judges one report and advances the residual history
  // ---------------------------------------------------------------------------
  function automatic result_t judge_report(item_t it);
    result_t     v;
    logic [63:0] f;
    logic [63:0] older;
    bit          active;
    bit          rise;
    f = it.residual_norm;
    v.status = ST_ITERATING;
    v.reason = RS_NONE;
    active = it.iteration >= cfg_mirror.forced_iterations;

    // start of solve: history restarts from the current residual
    if (it.iteration == 0) begin
      older = f;
      swing_count = '0;
    end else begin
      older = prev_residual;
    end

    // alternation count: odd count expects a fall, even a rise; saturates
    rise = dbl_lt(older, f);
    if (swing_count[0] ^ rise) begin
      if (swing_count != CNT_TOP) swing_count = swing_count + 1'b1;
    end else begin
      swing_count = '0;
    end

    // first chain, then domain error
    if (is_nan64(f)) begin
      v = '{ST_DIVERGED, RS_NAN};
    end else if (active && dbl_lt(f, cfg_mirror.abs_tolerance)) begin
      v = '{ST_CONVERGED, RS_ABS};
    end else if (it.evaluation_count >= cfg_mirror.max_evaluations) begin
      v = '{ST_DIVERGED, RS_EVALS};
    end else if (active && it.iteration != 0 && dbl_lt(prev_residual, f)
                 && dbl_le(LARGEST_DOUBLE, f)) begin
      v = '{ST_DIVERGED, RS_BLOWUP};
    end else if (it.domain_error) begin
      v = '{ST_DIVERGED, RS_DOMAIN};
    end

    // second chain, relative tests on products
    if (active && it.iteration != 0 && v.status == ST_ITERATING) begin
      if (dbl_le(f, dbl_mul(it.reference_norm, cfg_mirror.rel_tolerance))) begin
        v = '{ST_CONVERGED, RS_REL};
      end else if (dbl_lt(it.update_norm,
                          dbl_mul(cfg_mirror.rel_step_tolerance, it.solution_norm))) begin
        v = '{ST_CONVERGED, RS_STEP};
      end else if (dbl_lt('0, cfg_mirror.rel_div_tolerance) &&
                   dbl_lt(dbl_mul(it.reference_norm, cfg_mirror.rel_div_tolerance), f)) begin
        v = '{ST_DIVERGED, RS_RELDIV};
      end else if (dbl_lt('0, cfg_mirror.abs_div_tolerance) &&
                   dbl_lt(cfg_mirror.abs_div_tolerance, f)) begin
        v = '{ST_DIVERGED, RS_ABSDIV};
      end else if (swing_count > cfg_mirror.max_pingpong) begin
        v = '{ST_DIVERGED, RS_PINGPONG};
      end
    end

    prev_residual = f;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // register writes, only while nothing is in flight
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ABS_TOL:      cfg_mirror.abs_tolerance      = data;
      REG_REL_TOL:      cfg_mirror.rel_tolerance      = data;
      REG_STEP_TOL:     cfg_mirror.rel_step_tolerance = data;
      REG_MAX_EVALS:    cfg_mirror.max_evaluations    = data[15:0];
      REG_FORCED_ITERS: cfg_mirror.forced_iterations  = data[15:0];
      REG_REL_DIV_TOL:  cfg_mirror.rel_div_tolerance  = data;
      REG_ABS_DIV_TOL:  cfg_mirror.abs_div_tolerance  = data;
      default:          cfg_mirror.max_pingpong       = data[15:0];
    endcase
    reg_writes++;
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_ABS_TOL,      c.abs_tolerance);
    write_reg(REG_REL_TOL,      c.rel_tolerance);
    write_reg(REG_STEP_TOL,     c.rel_step_tolerance);
    write_reg(REG_MAX_EVALS,    {48'd0, c.max_evaluations});
    write_reg(REG_FORCED_ITERS, {48'd0, c.forced_iterations});
    write_reg(REG_REL_DIV_TOL,  c.rel_div_tolerance);
    write_reg(REG_ABS_DIV_TOL,  c.abs_div_tolerance);
    write_reg(REG_MAX_PINGPONG, {48'd0, c.max_pingpong});
    cfg_we <= 1'b0;
  endtask

  // drain: every verdict back, then an idle wait for the pipeline to settle
  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers one report, holds it until accepted, bursts with gaps
  // ---------------------------------------------------------------------------
  task automatic send_report(item_t it, bit typed, result_t typed_v, bit last);
    result_t v;
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    v = judge_report(it);
    verdict_q.push_back(typed ? typed_v : v);
    items_sent++;
    burst_left--;
    if (last || burst_left <= 0) begin
      push <= 1'b0;
      if (!last) begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
      end
    end
  endtask

  function automatic item_t make_report(logic [15:0] iter, logic [63:0] f, logic [63:0] x,
                                        logic [63:0] s, logic [63:0] r,
                                        logic [15:0] nev, logic dom);
    item_t it;
    it.iteration = iter;
    it.residual_norm = f;
    it.solution_norm = x;
    it.update_norm = s;
    it.reference_norm = r;
    it.evaluation_count = nev;
    it.domain_error = dom;
    return it;
  endfunction

  // odd doubles: raw bits, signed zeros, infinities, nan, largest, ordinary
  function automatic logic [63:0] odd_double();
    case ($urandom_range(0, 6))
      0: return {$urandom, $urandom};
      1: return $urandom_range(0, 1) ? DBL_NEG0 : 64'd0;
      2: return {$urandom_range(0, 1) == 1, DBL_INF[62:0]};
      3: return FP_QNAN | {$urandom_range(0, 1) == 1, 63'd0};
      4: return LARGEST_DOUBLE;
      default: return $realtobits(10.0 ** ($itor($urandom_range(0, 40)) - 20.0));
    endcase
  endfunction

  function automatic logic [63:0] maybe_odd(real v);
    return ($urandom_range(0, 24) == 0) ? odd_double() : $realtobits(v);
  endfunction

  // one solve: mostly well-formed sequences, some alternating, some noise
  task automatic run_solve(int budget, ref int sent);
    int  len;
    int  kind;
    real res;
    real sol;
    real ref_res;
    real upd;
    item_t it;
    logic [319:0] raw;
    len  = $urandom_range(1, 24);
    kind = $urandom_range(0, 9);
    res  = 10.0 ** ($itor($urandom_range(0, 12)) - 6.0);
    ref_res = res;
    sol  = $itor($urandom_range(1, 1000)) / 10.0;
    for (int k = 0; k < len && sent < budget; k++) begin
      upd = res * $itor($urandom_range(1, 1000)) / 100.0;
      if (kind < 2) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        if ($urandom_range(0, 1)) it.iteration = 16'($urandom_range(0, 4));
      end else begin
        it = make_report(16'(k), maybe_odd(res), maybe_odd(sol), maybe_odd(upd),
                         maybe_odd(ref_res),
                         16'(k * $urandom_range(1, 4) + $urandom_range(0, 2)),
                         $urandom_range(0, 15) == 0);
      end
      send_report(it, 1'b0, '0, 1'b0);
      sent++;
      // alternating solves bounce the residual to drive the swing count
      if (kind < 5) res = (k % 2 == 0) ? res * 3.0 : res * 0.4;
      else res = res * $itor($urandom_range(50, 1050)) / 1000.0;
    end
  endtask

  task automatic run_phase(cfg_t c, int budget);
    int sent;
    sent = 0;
    drain();
    load_config(c);
    while (sent < budget) run_solve(budget, sent);
    push <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: pops on a changing pattern, one long hold-off to fill the block
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    bit take;
    mode = 0;
    mode_left = 50;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected transaction: expected none, actual %0d/%0d",
                   $time, result.status, result.reason);
        end else begin
          result_t want;
          want = verdict_q.pop_front();
          verdict_hist[want.reason]++;
          if (want.status !== result.status || want.reason !== result.reason) begin
            mismatches++;
            $display("%0t mismatch status/reason: expected %0d/%0d, actual %0d/%0d",
                     $time, want.status, want.reason, result.status, result.reason);
          end
        end
        verdicts_seen++;
      end
      if (!hold_done && verdicts_seen == 60) begin
        // long stall while the sender keeps pushing, so full must assert
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (--mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      case (mode)
        0: take = 1'b1;
        1: take = $urandom_range(0, 1);
        default: take = ($urandom_range(0, 4) == 0);
      endcase
      pop <= take;
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table, then configuration phases with random solves
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t   it;
    bit      typed;
    result_t v;
  } row_t;

  initial begin : stimulus
    row_t rows[$];
    cfg_t c;
    logic [447:0] raw_cfg;

    cfg_mirror = '{abs_tolerance: '0, rel_tolerance: '0, rel_step_tolerance: '0,
                   max_evaluations: 16'hFFFF, forced_iterations: '0,
                   rel_div_tolerance: '0, abs_div_tolerance: '0, max_pingpong: 16'd100};
    prev_residual = '0;
    swing_count = '0;

    // reset defaults apply to the whole table
    rows.push_back('{make_report(0, DBL_ONE, DBL_ONE, DBL_ONE, DBL_ONE, 0, 0),
                     1, '{ST_ITERATING, RS_NONE}});
    rows.push_back('{make_report(1, DBL_HALF, DBL_ONE, DBL_ONE, DBL_ONE, 1, 0), 0, '0});
    rows.push_back('{make_report(2, FP_QNAN, DBL_ONE, DBL_ONE, DBL_ONE, 2, 0),
                     1, '{ST_DIVERGED, RS_NAN}});
    rows.push_back('{make_report(3, DBL_ONE, DBL_ONE, DBL_ONE, DBL_ONE, 16'hFFFF, 0),
                     1, '{ST_DIVERGED, RS_EVALS}});
    // domain error at solve start
    rows.push_back('{make_report(0, DBL_ONE, DBL_ONE, DBL_ONE, DBL_ONE, 0, 1),
                     1, '{ST_DIVERGED, RS_DOMAIN}});
    // blow-up to the largest double, then to infinity
    rows.push_back('{make_report(1, LARGEST_DOUBLE, DBL_ONE, DBL_ONE, DBL_ONE, 1, 0),
                     1, '{ST_DIVERGED, RS_BLOWUP}});
    rows.push_back('{make_report(2, DBL_INF, DBL_ONE, DBL_ONE, DBL_ONE, 2, 0), 0, '0});
    rows.push_back('{make_report(3, '0, DBL_ONE, DBL_ONE, '0, 3, 0), 0, '0});
    rows.push_back('{make_report(4, DBL_MONE, DBL_MONE, DBL_NEG0, DBL_TWO, 4, 0), 0, '0});
    rows.push_back('{make_report(16'hFFFF, DBL_NEG0, '1, 64'h7FFF_FFFF_FFFF_FFFF,
                                 DBL_INF, 16'hFFFE, 0), 0, '0});
    rows.push_back('{'1, 1, '{ST_DIVERGED, RS_NAN}});
    rows.push_back('{'0, 1, '{ST_ITERATING, RS_NONE}});
    // zero step against an infinite solution gives a nan product
    rows.push_back('{make_report(1, DBL_ONE, DBL_INF, '0, DBL_ONE, 1, 0), 0, '0});
    rows.push_back('{make_report(2, DBL_TWO, DBL_ONE, DBL_ONE, DBL_ONE, 2, 1),
                     1, '{ST_DIVERGED, RS_DOMAIN}});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_report(rows[i].it, rows[i].typed, rows[i].v, i == rows.size() - 1);

    // tight tolerances, swing limit low
    c = '{abs_tolerance: $realtobits(1e-10), rel_tolerance: $realtobits(1e-6),
          rel_step_tolerance: $realtobits(1e-12), max_evaluations: 16'hFFFF,
          forced_iterations: 0, rel_div_tolerance: '0, abs_div_tolerance: '0,
          max_pingpong: 16'd3};
    run_phase(c, 170);
    // extremes: no evaluations allowed, forced iterations at the maximum, divergence checks on
    c = '{abs_tolerance: '0, rel_tolerance: '0, rel_step_tolerance: '0,
          max_evaluations: 16'd0, forced_iterations: 16'hFFFF,
          rel_div_tolerance: $realtobits(1e4), abs_div_tolerance: $realtobits(1e10),
          max_pingpong: 16'd0};
    run_phase(c, 120);
    // divergence factors active, forced iterations small
    c = '{abs_tolerance: '0, rel_tolerance: $realtobits(1e-3),
          rel_step_tolerance: $realtobits(1e-8), max_evaluations: 16'd40,
          forced_iterations: 16'd2, rel_div_tolerance: $realtobits(10.0),
          abs_div_tolerance: $realtobits(1e6), max_pingpong: 16'hFFFF};
    run_phase(c, 170);
    // raw random register contents
    raw_cfg = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw_cfg[$bits(cfg_t)-1:0];
    run_phase(c, 150);
    // all ones: nan tolerances everywhere
    c = '1;
    run_phase(c, 120);
    // moderate setting, swing limit one, one forced iteration
    c = '{abs_tolerance: $realtobits(1e-8), rel_tolerance: $realtobits(1e-5),
          rel_step_tolerance: $realtobits(1e-9), max_evaluations: 16'd60,
          forced_iterations: 16'd1, rel_div_tolerance: $realtobits(100.0),
          abs_div_tolerance: $realtobits(1e4), max_pingpong: 16'd1};
    run_phase(c, 170);

    drain();
    $display("covered %0d reports, %0d verdicts, %0d register writes over 6 settings",
             items_sent, verdicts_seen, reg_writes);
    $display("verdicts by reason 0..10: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
             verdict_hist[4], verdict_hist[5], verdict_hist[6], verdict_hist[7],
             verdict_hist[8], verdict_hist[9], verdict_hist[10]);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nvcm_pkg.sv
hw/rtl/nvcm_queue.sv
hw/rtl/nvcm_front.sv
hw/rtl/nvcm_fmul.sv
hw/rtl/nvcm_back.sv
hw/rtl/newton_convergence_monitor_top.sv
hw/rtl/nvcm_checker.sv
bench/tb_newton_convergence_monitor_top.sv
